### hw/rtl/lafir_pkg.sv
`default_nettype none

package lafir_pkg;

	localparam int TAPS          = 256;
	localparam int HISTORY       = 512;
	localparam int BLOCK_SAMPLES = 128;

	localparam int SAMPLE_W   = 16;
	localparam int WEIGHT_W   = 32;
	localparam int MU_W       = 24;
	localparam int LAT_W      = 9;
	localparam int FRAC_SHIFT = 27;

	localparam int TAP_AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int HIST_AW   = (HISTORY > 1) ? $clog2(HISTORY) : 1;
	localparam int BLK_W     = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
	localparam int CLEAR_LEN = (TAPS > HISTORY) ? TAPS : HISTORY;
	localparam int CLR_W     = $clog2(CLEAR_LEN + 1);
	// wide enough for tap + latency and for head + HISTORY - offset
	localparam int K_W       = $clog2(TAPS + (1 << LAT_W) + 2 * HISTORY);

	localparam int EH_W    = 2 * SAMPLE_W;
	localparam int MPROD_W = MU_W + 1 + EH_W;
	localparam int FPROD_W = WEIGHT_W + SAMPLE_W;
	localparam int ACC_W   = FPROD_W + TAP_AW + 1;

	localparam int CFG_W     = MU_W;
	localparam int CFG_IDX_W = 1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [WEIGHT_W-1:0] weight_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_SIZE     = 1'b0,
		CFG_ERROR_LATENCY = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_UDRAIN,
		ST_HWRITE,
		ST_FIR,
		ST_FDRAIN,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

### hw/rtl/lafir_in_if.sv
`default_nettype none

interface lafir_in_if;
	logic                    valid;
	logic                    ready;
	lafir_pkg::sample_t      source_sample;
	lafir_pkg::sample_t      error_sample;

	modport source (output valid, source_sample, error_sample, input ready);
	modport sink   (input valid, source_sample, error_sample, output ready);
endinterface

`default_nettype wire

### hw/rtl/lafir_out_if.sv
`default_nettype none

interface lafir_out_if;
	logic                    valid;
	logic                    ready;
	lafir_pkg::sample_t      filtered_sample;

	modport source (output valid, filtered_sample, input ready);
	modport sink   (input valid, filtered_sample, output ready);
endinterface

`default_nettype wire

### hw/rtl/lafir_ram.sv
`default_nettype none

module lafir_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 512
) (
	input  wire                                        clk,
	input  wire                                        we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                            wdata,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/lms_adaptive_fir_filter_core.sv
`default_nettype none

// Channel   Dir   Transfer when      Payload
// in_ch     in    valid && ready     source_sample, error_sample (Q1.15)
// out_ch    out   valid && ready     filtered_sample (Q1.15, saturated)
// cfg       in    cfg_we             cfg_index, cfg_wdata (no read-back)
//
// Each item runs a dot-product pass over all TAPS weights from transfer to result,
// and the first item of a block also runs a pass that updates every weight. Both
// passes are bounded by the single read port of the weight and history memories:
// one tap per cycle through a short multiply pipeline.
// After reset a clearing pass over max(TAPS, HISTORY) = 512 addresses zeroes both
// memories; in_ch.ready stays low meanwhile. A finished result waits in the
// output register, and a new item is taken while it waits.

module lms_adaptive_fir_filter_core (
	input  wire                              clk,
	input  wire                              arst_n,
	lafir_in_if.sink                         in_ch,
	lafir_out_if.source                      out_ch,
	input  wire                              cfg_we,
	input  wire [lafir_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [lafir_pkg::CFG_W-1:0]       cfg_wdata
);

	lafir_pkg::state_t state_q, state_nx;

	logic [lafir_pkg::MU_W-1:0]    step_size_q;
	logic [lafir_pkg::LAT_W-1:0]   err_lat_q;
	logic [lafir_pkg::CLR_W-1:0]   clr_q;
	logic [lafir_pkg::TAP_AW-1:0]  idx_q;
	logic [lafir_pkg::HIST_AW-1:0] head_q, head_nx;
	logic [lafir_pkg::BLK_W-1:0]   blk_q;
	lafir_pkg::sample_t            src_q, err_q;

	// memory ports
	logic                          w_we, h_we;
	logic [lafir_pkg::TAP_AW-1:0]  w_waddr;
	logic [lafir_pkg::HIST_AW-1:0] h_waddr, h_raddr;
	lafir_pkg::weight_t            w_wdata, w_rdata;
	lafir_pkg::sample_t            h_wdata, h_rdata;

	logic issue_upd, issue_fir, in_xfer, out_load;
	logic upd_drained, fir_drained, clr_done, idx_last;

	// address of history offset k
	logic [lafir_pkg::K_W-1:0] k_off, h_sum, h_wrap;
	logic                      hz;

	// pipeline
	logic                          upd_s1, fir_s1, hz_s1;
	logic [lafir_pkg::TAP_AW-1:0]  idx_s1, idx_s2, idx_s3;
	logic                          upd_s2, fir_s2, upd_s3;
	logic signed [lafir_pkg::EH_W-1:0]    eh_s2;
	logic signed [lafir_pkg::FPROD_W-1:0] fprod_s2;
	logic signed [lafir_pkg::MPROD_W-1:0] mprod_s3;
	lafir_pkg::weight_t            w_s2, w_s3, w_new;
	lafir_pkg::sample_t            h1;
	logic signed [lafir_pkg::MPROD_W:0]   w_diff;
	logic [lafir_pkg::MPROD_W-lafir_pkg::WEIGHT_W+1:0] w_hi;

	logic signed [lafir_pkg::ACC_W-1:0] acc_q, acc_rnd, acc_shr;
	logic [lafir_pkg::ACC_W-lafir_pkg::SAMPLE_W:0] y_hi;
	lafir_pkg::sample_t                 y_sat, out_data_q;
	logic                               out_full_q;

	lafir_ram #(.WIDTH(lafir_pkg::WEIGHT_W), .DEPTH(lafir_pkg::TAPS)) u_weight_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (w_wdata),
		.raddr (idx_q),
		.rdata (w_rdata)
	);

	lafir_ram #(.WIDTH(lafir_pkg::SAMPLE_W), .DEPTH(lafir_pkg::HISTORY)) u_hist_ram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h_rdata)
	);

	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_load    = (state_q == lafir_pkg::ST_OUT) && (!out_full_q || out_ch.ready);
	assign clr_done    = (clr_q == lafir_pkg::CLR_W'(lafir_pkg::CLEAR_LEN - 1));
	assign idx_last    = (idx_q == lafir_pkg::TAP_AW'(lafir_pkg::TAPS - 1));
	assign upd_drained = !upd_s1 && !upd_s2 && !upd_s3;
	assign fir_drained = !fir_s1 && !fir_s2;
	assign head_nx     = (head_q == lafir_pkg::HIST_AW'(lafir_pkg::HISTORY - 1)) ?
		'0 : head_q + 1'b1;

	// history offset: tap (+ latency during update); beyond the depth reads as zero
	always_comb begin
		k_off = lafir_pkg::K_W'(idx_q);
		if (state_q == lafir_pkg::ST_UPDATE) begin
			k_off = k_off + lafir_pkg::K_W'(err_lat_q);
		end
		hz     = (k_off >= lafir_pkg::K_W'(lafir_pkg::HISTORY));
		h_sum  = lafir_pkg::K_W'(head_q) + lafir_pkg::K_W'(lafir_pkg::HISTORY) - k_off;
		h_wrap = (h_sum >= lafir_pkg::K_W'(lafir_pkg::HISTORY)) ?
			h_sum - lafir_pkg::K_W'(lafir_pkg::HISTORY) : h_sum;
	end

	assign h_raddr = h_wrap[lafir_pkg::HIST_AW-1:0];

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			lafir_pkg::ST_CLEAR: begin
				if (clr_done) state_nx = lafir_pkg::ST_IDLE;
			end
			lafir_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_nx = (blk_q == '0) ? lafir_pkg::ST_UPDATE : lafir_pkg::ST_HWRITE;
				end
			end
			lafir_pkg::ST_UPDATE: begin
				if (idx_last) state_nx = lafir_pkg::ST_UDRAIN;
			end
			lafir_pkg::ST_UDRAIN: begin
				if (upd_drained) state_nx = lafir_pkg::ST_HWRITE;
			end
			lafir_pkg::ST_HWRITE: begin
				state_nx = lafir_pkg::ST_FIR;
			end
			lafir_pkg::ST_FIR: begin
				if (idx_last) state_nx = lafir_pkg::ST_FDRAIN;
			end
			lafir_pkg::ST_FDRAIN: begin
				if (fir_drained) state_nx = lafir_pkg::ST_OUT;
			end
			lafir_pkg::ST_OUT: begin
				if (out_load) state_nx = lafir_pkg::ST_IDLE;
			end
			default: state_nx = lafir_pkg::ST_CLEAR;
		endcase
	end

	// outputs and memory writes
	always_comb begin
		in_ch.ready = 1'b0;
		issue_upd   = 1'b0;
		issue_fir   = 1'b0;
		w_we        = upd_s3;
		w_waddr     = idx_s3;
		w_wdata     = w_new;
		h_we        = 1'b0;
		h_waddr     = head_nx;
		h_wdata     = src_q;
		case (state_q)
			lafir_pkg::ST_CLEAR: begin
				w_we    = (clr_q < lafir_pkg::CLR_W'(lafir_pkg::TAPS));
				w_waddr = clr_q[lafir_pkg::TAP_AW-1:0];
				w_wdata = '0;
				h_we    = (clr_q < lafir_pkg::CLR_W'(lafir_pkg::HISTORY));
				h_waddr = clr_q[lafir_pkg::HIST_AW-1:0];
				h_wdata = '0;
			end
			lafir_pkg::ST_IDLE:   in_ch.ready = 1'b1;
			lafir_pkg::ST_UPDATE: issue_upd   = 1'b1;
			lafir_pkg::ST_HWRITE: h_we        = 1'b1;
			lafir_pkg::ST_FIR:    issue_fir   = 1'b1;
			default: ;
		endcase
	end

	// weight update arithmetic: w - floor(mu*e*h / 2^27), saturated
	always_comb begin
		w_diff = (lafir_pkg::MPROD_W + 1)'(w_s3)
			- (lafir_pkg::MPROD_W + 1)'(mprod_s3 >>> lafir_pkg::FRAC_SHIFT);
		w_hi = w_diff[lafir_pkg::MPROD_W:lafir_pkg::WEIGHT_W-1];
		if ((&w_hi) || !(|w_hi)) begin
			w_new = w_diff[lafir_pkg::WEIGHT_W-1:0];
		end else if (w_diff[lafir_pkg::MPROD_W]) begin
			w_new = {1'b1, {(lafir_pkg::WEIGHT_W-1){1'b0}}};
		end else begin
			w_new = {1'b0, {(lafir_pkg::WEIGHT_W-1){1'b1}}};
		end
	end

	// output: truncate toward zero, then saturate
	always_comb begin
		acc_rnd = acc_q + (acc_q[lafir_pkg::ACC_W-1] ?
			lafir_pkg::ACC_W'((1 << lafir_pkg::FRAC_SHIFT) - 1) : '0);
		acc_shr = acc_rnd >>> lafir_pkg::FRAC_SHIFT;
		y_hi    = acc_shr[lafir_pkg::ACC_W-1:lafir_pkg::SAMPLE_W-1];
		if ((&y_hi) || !(|y_hi)) begin
			y_sat = acc_shr[lafir_pkg::SAMPLE_W-1:0];
		end else if (acc_shr[lafir_pkg::ACC_W-1]) begin
			y_sat = {1'b1, {(lafir_pkg::SAMPLE_W-1){1'b0}}};
		end else begin
			y_sat = {1'b0, {(lafir_pkg::SAMPLE_W-1){1'b1}}};
		end
	end

	assign h1 = hz_s1 ? '0 : h_rdata;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lafir_pkg::ST_CLEAR;
			step_size_q <= '0;
			err_lat_q   <= '0;
			clr_q       <= '0;
			idx_q       <= '0;
			head_q      <= '0;
			blk_q       <= '0;
			upd_s1      <= 1'b0;
			fir_s1      <= 1'b0;
			upd_s2      <= 1'b0;
			fir_s2      <= 1'b0;
			upd_s3      <= 1'b0;
			out_full_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				case (lafir_pkg::cfg_idx_t'(cfg_index))
					lafir_pkg::CFG_STEP_SIZE:     step_size_q <= cfg_wdata[lafir_pkg::MU_W-1:0];
					lafir_pkg::CFG_ERROR_LATENCY: err_lat_q   <= cfg_wdata[lafir_pkg::LAT_W-1:0];
					default: ;
				endcase
			end
			if (state_q == lafir_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (issue_upd || issue_fir) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
			if (state_q == lafir_pkg::ST_HWRITE) begin
				head_q <= head_nx;
			end
			if (out_load) begin
				blk_q <= (blk_q == lafir_pkg::BLK_W'(lafir_pkg::BLOCK_SAMPLES - 1)) ?
					'0 : blk_q + 1'b1;
			end
			upd_s1 <= issue_upd;
			fir_s1 <= issue_fir;
			upd_s2 <= upd_s1;
			fir_s2 <= fir_s1;
			upd_s3 <= upd_s2;
			if (out_load) begin
				out_full_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_full_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			src_q <= in_ch.source_sample;
			err_q <= in_ch.error_sample;
		end
		hz_s1    <= hz;
		idx_s1   <= idx_q;
		idx_s2   <= idx_s1;
		idx_s3   <= idx_s2;
		eh_s2    <= err_q * h1;
		w_s2     <= w_rdata;
		fprod_s2 <= w_rdata * h1;
		mprod_s3 <= $signed({1'b0, step_size_q}) * eh_s2;
		w_s3     <= w_s2;
		if (state_q == lafir_pkg::ST_HWRITE) begin
			acc_q <= '0;
		end else if (fir_s2) begin
			acc_q <= acc_q + lafir_pkg::ACC_W'(fprod_s2);
		end
		if (out_load) begin
			out_data_q <= y_sat;
		end
	end

	assign out_ch.valid           = out_full_q;
	assign out_ch.filtered_sample = out_data_q;

	// weights must be settled before the dot product reads them
	a_wwrite_phase: assert property (@(posedge clk) disable iff (!arst_n)
		w_we |-> (state_q == lafir_pkg::ST_CLEAR || state_q == lafir_pkg::ST_UPDATE
			|| state_q == lafir_pkg::ST_UDRAIN))
		else $error("weight write outside clear/update phase");

	a_block_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && blk_q == '0) |=> state_q == lafir_pkg::ST_UPDATE)
		else $error("block start did not enter weight update");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_full_q) |-> $past(state_q) == lafir_pkg::ST_OUT)
		else $error("result appeared without a finished dot product");

	a_hist_write: assert property (@(posedge clk) disable iff (!arst_n)
		h_we |-> (state_q == lafir_pkg::ST_CLEAR || state_q == lafir_pkg::ST_HWRITE))
		else $error("history written outside clear/sample entry");

endmodule

`default_nettype wire
